// File: hw/rtl/multi_channel_message_watchdog_defines.svh
// ---------------------------------------------------------------------------
// multi-channel message watchdog: assertion macros
// shared assertion forms used by the port checker
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_MESSAGE_WATCHDOG_DEFINES_SVH
`define MULTI_CHANNEL_MESSAGE_WATCHDOG_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MCMW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mcmw assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define MCMW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mcmw assertion failed");

`endif

// File: hw/rtl/mcmw_pkg.sv
// ---------------------------------------------------------------------------
// mcmw_pkg
// widths, reset values and control types shared by the watchdog modules
// ---------------------------------------------------------------------------
package mcmw_pkg;

    // channel count default and number of timeout registers
    localparam int NUM_CHANNELS_DEF = 5;
    localparam int NUM_REGS         = 5;

    // field widths
    localparam int STAMP_W    = 62;
    localparam int CMD_W      = 16;
    localparam int CHAN_W     = 3;
    localparam int MASK_W     = 5;
    localparam int TIMEOUT_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // 0.5 s in nanoseconds
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd500000000;

    // input mode codes
    localparam logic MODE_REFRESH = 1'b0;
    localparam logic MODE_CHECK   = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic refresh;   // store stamp for the addressed channel
        logic capture;   // latch a check transaction
        logic evaluate;  // compare all channels and strobe the result
    } t_dp_cmd;

endpackage

// File: hw/rtl/mcmw_ctrl.sv
// ---------------------------------------------------------------------------
// mcmw_ctrl
// controller: accepts transactions and sequences the check evaluation
// ---------------------------------------------------------------------------
module mcmw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_mode,
    output logic              busy,
    output mcmw_pkg::t_dp_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    // transaction accepted only when idle
    assign busy   = (r_state == ST_EVAL);
    assign accept = start && !busy;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_mode == mcmw_pkg::MODE_CHECK)) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath commands
    assign o_cmd.refresh  = accept && (i_mode == mcmw_pkg::MODE_REFRESH);
    assign o_cmd.capture  = accept && (i_mode == mcmw_pkg::MODE_CHECK);
    assign o_cmd.evaluate = (r_state == ST_EVAL);

endmodule

// File: hw/rtl/mcmw_dp.sv
// ---------------------------------------------------------------------------
// mcmw_dp
// datapath: timeout registers, per-channel stamps, parallel silence compare
// ---------------------------------------------------------------------------
module mcmw_dp #(
    parameter int NUM_CHANNELS = mcmw_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mcmw_pkg::t_dp_cmd                     i_cmd,
    input  logic [mcmw_pkg::CHAN_W-1:0]           i_channel,
    input  logic [mcmw_pkg::STAMP_W-1:0]          i_stamp,
    input  logic signed [mcmw_pkg::CMD_W-1:0]     i_accel_in,
    input  logic signed [mcmw_pkg::CMD_W-1:0]     i_speed_in,
    input  logic                                  i_cfg_we,
    input  logic [mcmw_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mcmw_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    output logic                                  o_valid,
    output logic signed [mcmw_pkg::CMD_W-1:0]     o_accel_out,
    output logic signed [mcmw_pkg::CMD_W-1:0]     o_speed_out,
    output logic                                  o_tripped,
    output logic [mcmw_pkg::MASK_W-1:0]           o_unseen_mask,
    output logic [mcmw_pkg::MASK_W-1:0]           o_expired_mask
);

    localparam int SW = mcmw_pkg::STAMP_W;
    localparam int TW = mcmw_pkg::TIMEOUT_W;
    localparam int MW = mcmw_pkg::MASK_W;

    logic [TW-1:0]                    r_timeout [NUM_CHANNELS];
    logic [SW-1:0]                    r_last    [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]          r_seen;
    logic [SW-1:0]                    r_stamp;
    logic signed [mcmw_pkg::CMD_W-1:0] r_accel;
    logic signed [mcmw_pkg::CMD_W-1:0] r_speed;

    logic                             r_valid;
    logic signed [mcmw_pkg::CMD_W-1:0] r_accel_out;
    logic signed [mcmw_pkg::CMD_W-1:0] r_speed_out;
    logic                             r_tripped;
    logic [MW-1:0]                    r_unseen;
    logic [MW-1:0]                    r_expired;

    logic [NUM_CHANNELS-1:0]          n_unseen_full;
    logic [NUM_CHANNELS-1:0]          n_expired_full;
    logic [MW-1:0]                    n_unseen;
    logic [MW-1:0]                    n_expired;
    logic                             n_tripped;

    // timeout registers, written through the config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_timeout[c] <= mcmw_pkg::TIMEOUT_RESET;
            end
        end else if (i_cfg_we) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if ((c < mcmw_pkg::NUM_REGS) &&
                    (i_cfg_index == mcmw_pkg::CFG_IDX_W'(c))) begin
                    r_timeout[c] <= i_cfg_wdata[TW-1:0];
                end
            end
        end
    end

    // seen flags, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_cmd.refresh) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (i_channel == mcmw_pkg::CHAN_W'(c)) begin
                    r_seen[c] <= 1'b1;
                end
            end
        end
    end

    // last stamp per channel, only read once seen
    always_ff @(posedge i_clk) begin
        if (i_cmd.refresh) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (i_channel == mcmw_pkg::CHAN_W'(c)) begin
                    r_last[c] <= i_stamp;
                end
            end
        end
    end

    // check transaction capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_stamp <= i_stamp;
            r_accel <= i_accel_in;
            r_speed <= i_speed_in;
        end
    end

    // one subtract-and-compare lane per channel
    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
        logic [SW:0] diff;
        logic        over;
        assign diff = {1'b0, r_stamp} - {1'b0, r_last[c]};
        // negative difference never expires
        assign over = !diff[SW] &&
                      ((diff[SW-1:TW] != '0) || (diff[TW-1:0] > r_timeout[c]));
        assign n_unseen_full[c]  = !r_seen[c];
        assign n_expired_full[c] = r_seen[c] && over;
    end

    // fit channel masks to the result field width
    for (genvar b = 0; b < MW; b++) begin : g_mask
        if (b < NUM_CHANNELS) begin : g_used
            assign n_unseen[b]  = n_unseen_full[b];
            assign n_expired[b] = n_expired_full[b];
        end else begin : g_unused
            assign n_unseen[b]  = 1'b0;
            assign n_expired[b] = 1'b0;
        end
    end

    assign n_tripped = (n_unseen_full != '0) || (n_expired_full != '0);

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.evaluate;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.evaluate) begin
            r_tripped   <= n_tripped;
            r_unseen    <= n_unseen;
            r_expired   <= n_expired;
            r_accel_out <= n_tripped ? '0 : r_accel;
            r_speed_out <= n_tripped ? '0 : r_speed;
        end
    end

    assign o_valid        = r_valid;
    assign o_accel_out    = r_accel_out;
    assign o_speed_out    = r_speed_out;
    assign o_tripped      = r_tripped;
    assign o_unseen_mask  = r_unseen;
    assign o_expired_mask = r_expired;

endmodule

// File: hw/rtl/multi_channel_message_watchdog.sv
// ---------------------------------------------------------------------------
// multi_channel_message_watchdog
// watchdog over message channels that gates accelerator and speed commands
// ---------------------------------------------------------------------------
// A refresh transaction (mode 0) leaves busy low, so refreshes may arrive
// every cycle while no check holds busy. A check transaction (mode 1) raises
// busy for one cycle while all channels go through their 62-bit subtract and
// timeout compare from registered operands. o_valid is registered from the
// evaluate command, rises at the edge that ends the busy cycle and stays high
// for exactly one cycle; busy is already low in that cycle, so a new
// transaction is taken alongside the result. There is no back-pressure: the
// result must be taken in the cycle o_valid is high. Timeout writes go in at
// any edge with i_cfg_we high and should be made only while the block is idle.
module multi_channel_message_watchdog #(
    parameter int NUM_CHANNELS = mcmw_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_mode,
    input  logic [mcmw_pkg::CHAN_W-1:0]           i_channel,
    input  logic [mcmw_pkg::STAMP_W-1:0]          i_stamp,
    input  logic signed [mcmw_pkg::CMD_W-1:0]     i_accel_in,
    input  logic signed [mcmw_pkg::CMD_W-1:0]     i_speed_in,
    input  logic                                  i_cfg_we,
    input  logic [mcmw_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mcmw_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    output logic                                  o_valid,
    output logic signed [mcmw_pkg::CMD_W-1:0]     o_accel_out,
    output logic signed [mcmw_pkg::CMD_W-1:0]     o_speed_out,
    output logic                                  o_tripped,
    output logic [mcmw_pkg::MASK_W-1:0]           o_unseen_mask,
    output logic [mcmw_pkg::MASK_W-1:0]           o_expired_mask
);

    mcmw_pkg::t_dp_cmd cmd;

    // controller
    mcmw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // datapath
    mcmw_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_channel      (i_channel),
        .i_stamp        (i_stamp),
        .i_accel_in     (i_accel_in),
        .i_speed_in     (i_speed_in),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_accel_out    (o_accel_out),
        .o_speed_out    (o_speed_out),
        .o_tripped      (o_tripped),
        .o_unseen_mask  (o_unseen_mask),
        .o_expired_mask (o_expired_mask)
    );

endmodule

// File: hw/rtl/mcmw_checker.sv
// ---------------------------------------------------------------------------
// mcmw_checker
// port-level checks on transaction sequencing and result consistency
// ---------------------------------------------------------------------------
`include "multi_channel_message_watchdog_defines.svh"

module mcmw_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic                                  i_mode,
    input  logic                                  o_valid,
    input  logic signed [mcmw_pkg::CMD_W-1:0]     o_accel_out,
    input  logic signed [mcmw_pkg::CMD_W-1:0]     o_speed_out,
    input  logic                                  o_tripped,
    input  logic [mcmw_pkg::MASK_W-1:0]           o_unseen_mask,
    input  logic [mcmw_pkg::MASK_W-1:0]           o_expired_mask
);

    // an accepted check holds the block busy for the compare cycle
    `MCMW_ASSERT_NXT(a_check_busy, start && !busy && (i_mode == mcmw_pkg::MODE_CHECK), busy)

    // the compare cycle always ends in a result strobe
    `MCMW_ASSERT_NXT(a_busy_result, busy, o_valid && !busy)

    // a flagged channel always trips the gate
    `MCMW_ASSERT_IMP(a_flag_trips, o_valid && ((o_unseen_mask | o_expired_mask) != '0), o_tripped)

    // a tripped result carries zero commands
    `MCMW_ASSERT_IMP(a_trip_zero, o_valid && o_tripped, (o_accel_out == '0) && (o_speed_out == '0))

    // no channel is both unseen and expired
    `MCMW_ASSERT_IMP(a_mask_disjoint, o_valid, (o_unseen_mask & o_expired_mask) == '0)

endmodule

bind multi_channel_message_watchdog mcmw_checker u_mcmw_checker (.*);

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench for multi_channel_message_watchdog
// drives refresh and check transactions on five message channels, tracks
// channel times, seen flags and timeouts in a local model, and compares
// every strobed verdict field by field against the predicted one
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // shared widths and codes
    localparam int CHAN_W     = mcmw_pkg::CHAN_W;
    localparam int STAMP_W    = mcmw_pkg::STAMP_W;
    localparam int CMD_W      = mcmw_pkg::CMD_W;
    localparam int MASK_W     = mcmw_pkg::MASK_W;
    localparam int TIMEOUT_W  = mcmw_pkg::TIMEOUT_W;
    localparam int CFG_IDX_W  = mcmw_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = mcmw_pkg::CFG_DATA_W;
    localparam int NUM_REGS   = mcmw_pkg::NUM_REGS;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = mcmw_pkg::TIMEOUT_RESET;
    localparam logic MODE_REFRESH = mcmw_pkg::MODE_REFRESH;
    localparam logic MODE_CHECK   = mcmw_pkg::MODE_CHECK;

    // channel numbers; the timeout register of a channel has the same index
    localparam int CH_KINEMATIC  = 0;
    localparam int CH_MANUAL     = 1;
    localparam int CH_OUTPUT     = 2;
    localparam int CH_TRAJECTORY = 3;
    localparam int CH_TTL        = 4;
    localparam int NUM_CH        = mcmw_pkg::NUM_CHANNELS_DEF;
    localparam int CFG_INDEX_TOP = (1 << CFG_IDX_W) - 1;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = {TIMEOUT_W{1'b1}};

    // how the timeouts of a random phase are picked
    typedef enum int {
        PROFILE_DEFAULT,
        PROFILE_WIDE,
        PROFILE_TIGHT,
        PROFILE_EXTREME
    } t_timeout_profile;

    typedef struct packed {
        logic                     mode;
        logic [CHAN_W-1:0]        chan;
        logic [STAMP_W-1:0]       stamp;
        logic signed [CMD_W-1:0]  accel;
        logic signed [CMD_W-1:0]  speed;
    } t_watch_txn;

    typedef struct packed {
        logic signed [CMD_W-1:0]  accel;
        logic signed [CMD_W-1:0]  speed;
        logic                     tripped;
        logic [MASK_W-1:0]        unseen;
        logic [MASK_W-1:0]        expired;
    } t_guard_verdict;

    // dut ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_mode = MODE_REFRESH;
    logic [CHAN_W-1:0]         i_channel = '0;
    logic [STAMP_W-1:0]        i_stamp = '0;
    logic signed [CMD_W-1:0]   i_accel_in = '0;
    logic signed [CMD_W-1:0]   i_speed_in = '0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_wdata = '0;
    logic                      o_valid;
    logic signed [CMD_W-1:0]   o_accel_out;
    logic signed [CMD_W-1:0]   o_speed_out;
    logic                      o_tripped;
    logic [MASK_W-1:0]         o_unseen_mask;
    logic [MASK_W-1:0]         o_expired_mask;

    // local copy of the watchdog state
    logic [STAMP_W-1:0]   chan_last_time [NUM_CH];
    logic                 chan_seen [NUM_CH];
    logic [TIMEOUT_W-1:0] chan_timeout [NUM_CH];

    t_guard_verdict pending_verdicts [$];
    t_guard_verdict got_verdict;
    t_guard_verdict want_verdict;
    int mismatches = 0;
    int burst_left = 0;

    multi_channel_message_watchdog #(
        .NUM_CHANNELS(NUM_CH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_channel     (i_channel),
        .i_stamp       (i_stamp),
        .i_accel_in    (i_accel_in),
        .i_speed_in    (i_speed_in),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_accel_out   (o_accel_out),
        .o_speed_out   (o_speed_out),
        .o_tripped     (o_tripped),
        .o_unseen_mask (o_unseen_mask),
        .o_expired_mask(o_expired_mask)
    );

    // clock
    always #6 i_clk = ~i_clk;

    // random helpers
    function automatic logic [STAMP_W-1:0] rand_stamp();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[STAMP_W-1:0];
    endfunction

    function automatic logic signed [CMD_W-1:0] rand_cmd();
        logic [31:0] r;
        r = $urandom;
        return r[CMD_W-1:0];
    endfunction

    // update channel state on a refresh, or judge all channels on a check
    task automatic apply_to_watch_model(input t_watch_txn t);
        t_guard_verdict v;
        logic [63:0] silence;
        if (t.mode == MODE_REFRESH) begin
            if (int'(t.chan) < NUM_CH) begin
                chan_last_time[t.chan] = t.stamp;
                chan_seen[t.chan] = 1'b1;
            end
        end else begin
            v = '0;
            for (int c = 0; c < NUM_CH; c++) begin
                if (!chan_seen[c]) begin
                    v.unseen[c] = 1'b1;
                end else begin
                    // signed 64-bit difference: a negative one never expires
                    silence = {2'b00, t.stamp} - {2'b00, chan_last_time[c]};
                    if (!silence[63] && silence > {32'b0, chan_timeout[c]})
                        v.expired[c] = 1'b1;
                end
            end
            v.tripped = (v.unseen != '0) || (v.expired != '0);
            v.accel = v.tripped ? '0 : t.accel;
            v.speed = v.tripped ? '0 : t.speed;
            pending_verdicts.push_back(v);
        end
    endtask

    // send one transaction, with random gaps between bursts
    task automatic send_item(input t_watch_txn t);
        bit took;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20)
                                               : $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        start      <= 1'b1;
        i_mode     <= t.mode;
        i_channel  <= t.chan;
        i_stamp    <= t.stamp;
        i_accel_in <= t.accel;
        i_speed_in <= t.speed;
        // busy is stable from the falling edge up to the next rising edge
        do begin
            @(negedge i_clk);
            took = !busy;
            @(posedge i_clk);
        end while (!took);
        apply_to_watch_model(t);
    endtask

    task automatic send_refresh(input int ch, input logic [STAMP_W-1:0] stamp);
        t_watch_txn t;
        t.mode  = MODE_REFRESH;
        t.chan  = ch[CHAN_W-1:0];
        t.stamp = stamp;
        t.accel = rand_cmd();
        t.speed = rand_cmd();
        send_item(t);
    endtask

    task automatic send_check(input logic [STAMP_W-1:0] stamp,
                              input logic signed [CMD_W-1:0] accel,
                              input logic signed [CMD_W-1:0] speed);
        t_watch_txn t;
        t.mode  = MODE_CHECK;
        t.chan  = CHAN_W'($urandom_range(0, CFG_INDEX_TOP));
        t.stamp = stamp;
        t.accel = accel;
        t.speed = speed;
        send_item(t);
    endtask

    // stop sending and let every outstanding verdict come back
    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, only while idle
    task automatic write_timeout(input int idx, input logic [TIMEOUT_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx[CFG_IDX_W-1:0];
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx < NUM_REGS && idx < NUM_CH)
            chan_timeout[idx] = val;
    endtask

    // verdict checker: results cannot be held off, so take each strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            got_verdict = {o_accel_out, o_speed_out, o_tripped,
                           o_unseen_mask, o_expired_mask};
            if (pending_verdicts.size() == 0) begin
                $error("verdict with no check transaction pending");
                mismatches++;
            end else begin
                want_verdict = pending_verdicts.pop_front();
                if (got_verdict.accel !== want_verdict.accel) begin
                    $error("accel_out: expected %0d, got %0d",
                           want_verdict.accel, got_verdict.accel);
                    mismatches++;
                end
                if (got_verdict.speed !== want_verdict.speed) begin
                    $error("speed_out: expected %0d, got %0d",
                           want_verdict.speed, got_verdict.speed);
                    mismatches++;
                end
                if (got_verdict.tripped !== want_verdict.tripped) begin
                    $error("tripped: expected %0b, got %0b",
                           want_verdict.tripped, got_verdict.tripped);
                    mismatches++;
                end
                if (got_verdict.unseen !== want_verdict.unseen) begin
                    $error("unseen_mask: expected %05b, got %05b",
                           want_verdict.unseen, got_verdict.unseen);
                    mismatches++;
                end
                if (got_verdict.expired !== want_verdict.expired) begin
                    $error("expired_mask: expected %05b, got %05b",
                           want_verdict.expired, got_verdict.expired);
                    mismatches++;
                end
            end
        end
    end

    // every channel unseen right after reset, then only some
    task automatic test_unseen_after_reset();
        send_check('0, 16'sh7FFF, -16'sh8000);
        send_refresh(CH_KINEMATIC, 62'd100);
        send_refresh(CH_OUTPUT, 62'd100);
        send_check(62'd100, rand_cmd(), rand_cmd());
    endtask

    // all channels fresh: commands pass, silence equal to timeout is fine
    task automatic test_pass_through();
        send_refresh(CH_MANUAL, 62'd1000);
        send_refresh(CH_TRAJECTORY, 62'd1000);
        send_refresh(CH_TTL, 62'd1000);
        send_refresh(CH_KINEMATIC, 62'd1000);
        send_refresh(CH_OUTPUT, 62'd1000);
        send_check(62'd1000, -16'sh8000, 16'sh7FFF);
        send_check(62'd1000 + STAMP_W'(TIMEOUT_RESET), 16'sh7FFF, -16'sh8000);
    endtask

    // one nanosecond past the timeout trips every channel
    task automatic test_timeout_exceeded();
        send_check(62'd1001 + STAMP_W'(TIMEOUT_RESET), rand_cmd(), rand_cmd());
    endtask

    // stamp older than the last refresh gives a negative silence
    task automatic test_older_stamp();
        send_check('0, rand_cmd(), rand_cmd());
    endtask

    // refresh of a channel that does not exist changes nothing
    task automatic test_channel_out_of_range();
        send_refresh(NUM_CH, STAMP_MAX);
        send_check(62'd1000, rand_cmd(), rand_cmd());
        // largest stamp on one channel, the rest far behind
        send_refresh(CH_TTL, STAMP_MAX);
        send_check(STAMP_MAX, rand_cmd(), rand_cmd());
    endtask

    // zero and full-scale timeouts, writes to missing registers ignored
    task automatic test_timeout_extremes();
        logic [STAMP_W-1:0] base;
        base = 62'd2000;
        drain();
        write_timeout(CH_KINEMATIC, '0);
        write_timeout(CH_MANUAL, TIMEOUT_MAX);
        write_timeout(CH_OUTPUT, 32'd1);
        write_timeout(CH_TRAJECTORY, 32'h7FFF_FFFF);
        write_timeout(CH_TTL, 32'h8000_0000);
        for (int idx = NUM_REGS; idx <= CFG_INDEX_TOP; idx++)
            write_timeout(idx, '0);
        for (int c = 0; c < NUM_CH; c++)
            send_refresh(c, base);
        send_check(base, rand_cmd(), rand_cmd());
        send_check(base + 62'd1, rand_cmd(), rand_cmd());
        send_check(base + STAMP_W'(TIMEOUT_MAX), rand_cmd(), rand_cmd());
        send_check(base + STAMP_W'(TIMEOUT_MAX) + 62'd1, rand_cmd(), rand_cmd());
    endtask

    function automatic logic [TIMEOUT_W-1:0] pick_timeout(t_timeout_profile prof);
        case (prof)
            PROFILE_WIDE:  return $urandom;
            PROFILE_TIGHT: return $urandom_range(0, 2000);
            PROFILE_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return TIMEOUT_MAX;
                    2:       return 32'd1;
                    default: return $urandom_range(0, 50);
                endcase
            end
            default:       return TIMEOUT_RESET;
        endcase
    endfunction

    // a random phase: program timeouts, then mostly time-ordered traffic
    task automatic test_random_phase(input int n_items, input t_timeout_profile prof);
        logic [STAMP_W-1:0] now_ns;
        logic [STAMP_W-1:0] s;
        int unsigned step_max;
        int sel;
        int c;
        drain();
        for (int idx = 0; idx < NUM_REGS; idx++)
            write_timeout(idx, pick_timeout(prof));
        write_timeout($urandom_range(NUM_REGS, CFG_INDEX_TOP), $urandom);

        // time base: near the top of the stamp range, near zero, or anywhere
        case ($urandom_range(0, 3))
            0:       now_ns = STAMP_MAX - STAMP_W'($urandom_range(0, 200000));
            1:       now_ns = STAMP_W'($urandom_range(0, 100000));
            default: now_ns = rand_stamp();
        endcase
        step_max = (chan_timeout[$urandom_range(0, NUM_CH - 1)] >> 2) + 3;

        for (int n = 0; n < n_items; n++) begin
            sel = $urandom_range(0, 99);
            c = $urandom_range(0, NUM_CH - 1);
            if (sel < 45) begin
                send_refresh(c, now_ns);
                now_ns = now_ns + STAMP_W'($urandom_range(0, step_max));
            end else if (sel < 50) begin
                // noise: any channel number, any stamp
                send_refresh($urandom_range(0, CFG_INDEX_TOP), rand_stamp());
            end else if (sel < 80) begin
                send_check(now_ns, rand_cmd(), rand_cmd());
            end else if (sel < 92) begin
                // just below, at, or just past one channel's timeout
                s = chan_last_time[c] + STAMP_W'(chan_timeout[c])
                    + STAMP_W'($urandom_range(0, 2)) - 62'd1;
                send_check(s, rand_cmd(), rand_cmd());
            end else if (sel < 96) begin
                s = chan_last_time[c] - STAMP_W'($urandom_range(1, 1000));
                send_check(s, rand_cmd(), rand_cmd());
            end else begin
                send_check(rand_stamp(), rand_cmd(), rand_cmd());
            end
        end
    endtask

    // test sequence
    initial begin
        for (int c = 0; c < NUM_CH; c++) begin
            chan_last_time[c] = '0;
            chan_seen[c] = 1'b0;
            chan_timeout[c] = TIMEOUT_RESET;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unseen_after_reset();
        test_pass_through();
        test_timeout_exceeded();
        test_older_stamp();
        test_channel_out_of_range();
        test_timeout_extremes();

        test_random_phase(118, PROFILE_EXTREME);
        test_random_phase(118, PROFILE_WIDE);
        test_random_phase(118, PROFILE_TIGHT);
        test_random_phase(118, PROFILE_DEFAULT);
        test_random_phase(118, PROFILE_TIGHT);
        test_random_phase(118, PROFILE_EXTREME);
        test_random_phase(118, PROFILE_WIDE);
        test_random_phase(118, PROFILE_TIGHT);

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("multi_channel_message_watchdog: match");
        else
            $display("multi_channel_message_watchdog: mismatch");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("multi_channel_message_watchdog: mismatch");
        $finish;
    end

endmodule
